/* rtl/epdd_pkg.sv */
// package for the echo pulse to decimal display unit
// shared widths, register indexes, reset values and engine handshake structs
// no dependencies
`timescale 1ns / 1ps

package epdd_pkg;

  localparam int DIGIT_COUNT_DEF = 4;
  localparam int TIME_BITS_DEF   = 24;

  localparam int CAPTURE_W = 24;
  localparam int SPEED_W   = 10;
  localparam int CPM_W     = 18;
  localparam int DIV_W     = CPM_W + 1;
  localparam int DIGIT_W   = 4;
  localparam int OUT_DIGITS = 4;
  localparam int IN_W      = 24;
  localparam int OUT_W     = 24;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = CPM_W;

  localparam logic [CFG_IDX_W-1:0] REG_SPEED = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CPM   = 1'd1;

  localparam logic [SPEED_W-1:0] SPEED_RST = 10'd343;
  localparam logic [CPM_W-1:0]   CPM_RST   = 18'd16000;

  typedef struct packed {
    logic start;
    logic take;
  } epdd_ctrl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } epdd_stat_t;

endpackage

/* rtl/epdd_engine.sv */
// bit-serial multiply, restoring divide and double-dabble decimal conversion
// depends on epdd_pkg
`timescale 1ns / 1ps

module epdd_engine #(
  parameter int DIGIT_COUNT = epdd_pkg::DIGIT_COUNT_DEF,
  parameter int TIME_BITS   = epdd_pkg::TIME_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  epdd_pkg::epdd_ctrl_t                     ctrl,
  output epdd_pkg::epdd_stat_t                     stat,
  input  logic [TIME_BITS-1:0]                     ticks,
  input  logic [epdd_pkg::SPEED_W-1:0]             speed,
  input  logic [epdd_pkg::DIV_W-1:0]               divisor,
  output logic [DIGIT_COUNT*epdd_pkg::DIGIT_W-1:0] bcd
);

  localparam int PW    = TIME_BITS + epdd_pkg::SPEED_W;
  localparam int CNT_W = $clog2(PW + 1);
  localparam int BCD_W = DIGIT_COUNT * epdd_pkg::DIGIT_W;
  localparam int DW    = epdd_pkg::DIGIT_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_HOLD = 4'b1000
  } state_t;

  state_t                         state_r, state_nxt;
  logic [CNT_W-1:0]               cnt_r, cnt_nxt;
  logic [TIME_BITS-1:0]           mcand_r, mcand_nxt;
  logic [epdd_pkg::SPEED_W-1:0]   spd_r, spd_nxt;
  logic [epdd_pkg::DIV_W-1:0]     div_r, div_nxt;
  logic [PW-1:0]                  acc_r, acc_nxt;
  logic [epdd_pkg::DIV_W-1:0]     rem_r, rem_nxt;
  logic [BCD_W-1:0]               bcd_r, bcd_nxt;
  logic [epdd_pkg::DIV_W:0]       trial;
  logic                           q_bit;
  logic [BCD_W-1:0]               bcd_adj;

  // one quotient bit per cycle, fed straight into the decimal shifter
  always_comb begin
    trial = {rem_r, acc_r[PW-1]};
    q_bit = (trial >= {1'b0, div_r});
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      bcd_adj[i*DW +: DW] = (bcd_r[i*DW +: DW] >= DW'(5)) ?
                            (bcd_r[i*DW +: DW] + DW'(3)) : bcd_r[i*DW +: DW];
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    mcand_nxt = mcand_r;
    spd_nxt   = spd_r;
    div_nxt   = div_r;
    acc_nxt   = acc_r;
    rem_nxt   = rem_r;
    bcd_nxt   = bcd_r;
    unique case (state_r)
      S_IDLE: begin
        if (ctrl.start) begin
          mcand_nxt = ticks;
          spd_nxt   = speed;
          div_nxt   = divisor;
          acc_nxt   = '0;
          rem_nxt   = '0;
          bcd_nxt   = '0;
          cnt_nxt   = CNT_W'(epdd_pkg::SPEED_W);
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        // msb-first shift and add over the speed bits
        acc_nxt = {acc_r[PW-2:0], 1'b0} +
                  (spd_r[epdd_pkg::SPEED_W-1] ? PW'(mcand_r) : PW'(0));
        spd_nxt = {spd_r[epdd_pkg::SPEED_W-2:0], 1'b0};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          cnt_nxt   = CNT_W'(PW);
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        acc_nxt = {acc_r[PW-2:0], 1'b0};
        rem_nxt = q_bit ? epdd_pkg::DIV_W'(trial - {1'b0, div_r})
                        : trial[epdd_pkg::DIV_W-1:0];
        // carry out of the top digit drops, keeping the low digits only
        bcd_nxt = {bcd_adj[BCD_W-2:0], q_bit};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        if (ctrl.take) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mcand_r <= mcand_nxt;
    spd_r   <= spd_nxt;
    div_r   <= div_nxt;
    acc_r   <= acc_nxt;
    rem_r   <= rem_nxt;
    bcd_r   <= bcd_nxt;
  end

  assign stat.idle = (state_r == S_IDLE);
  assign stat.done = (state_r == S_HOLD);
  assign bcd       = bcd_r;

endmodule

/* rtl/echo_pulse_to_decimal_display_unit.sv */
// top level: echo edge capture, distance engine and registered display result
// depends on epdd_pkg and epdd_engine
//
// channel  dir  handshake          payload
// in_      in   tvalid / tready    tuser: edge_rising, tdata: capture_time
// out_     out  tvalid / tready    tdata: four digits and four show flags
// cfg_     in   we (no wait)       addr: register index, wdata: value
//
// a rising edge only stores its capture time and gives no beat on the output
// a falling edge runs the serial multiplier over the speed bits, then the
// restoring divider over the product bits, whose quotient bits feed the
// double-dabble shifter
// the result waits in an output register; a new edge is taken while it waits
// reset is synchronous, active low; registers return to 343 and 16000

`timescale 1ns / 1ps

module echo_pulse_to_decimal_display_unit #(
  parameter int DIGIT_COUNT = epdd_pkg::DIGIT_COUNT_DEF,
  parameter int TIME_BITS   = epdd_pkg::TIME_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [epdd_pkg::IN_W-1:0]        in_tdata,   // [23:0] capture_time
  input  logic [0:0]                       in_tuser,   // [0] edge_rising
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [3:0] digit_ones, [7:4] digit_tens, [11:8] digit_hundreds,
  // [15:12] digit_thousands, [16] show_ones, [17] show_tens,
  // [18] show_hundreds, [19] show_thousands, [23:20] zero
  output logic [epdd_pkg::OUT_W-1:0]       out_tdata,
  input  logic                             cfg_we,
  input  logic [epdd_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [epdd_pkg::CFG_W-1:0]       cfg_wdata
);

  localparam int CW    = epdd_pkg::CAPTURE_W;
  localparam int MAXW  = (TIME_BITS > CW) ? TIME_BITS : CW;
  localparam int DW    = epdd_pkg::DIGIT_W;
  localparam int ND    = epdd_pkg::OUT_DIGITS;
  localparam int MAXD  = (DIGIT_COUNT > ND) ? DIGIT_COUNT : ND;
  localparam int BCD_W = DIGIT_COUNT * DW;
  localparam int FLD_W = ND * DW + ND;

  logic [epdd_pkg::SPEED_W-1:0] speed_r;
  logic [epdd_pkg::CPM_W-1:0]   cpm_r;
  logic [TIME_BITS-1:0]         start_r;
  logic                         out_valid_r, out_valid_nxt;
  logic [epdd_pkg::OUT_W-1:0]   out_data_r, out_data_nxt;

  logic [MAXW-1:0]              cap_ext;
  logic [TIME_BITS-1:0]         now_t;
  logic [TIME_BITS-1:0]         ticks;
  logic [epdd_pkg::CPM_W-1:0]   cpm_eff;
  logic [epdd_pkg::DIV_W-1:0]   divisor;
  logic                         in_beat;
  epdd_pkg::epdd_ctrl_t         eng_ctrl;
  epdd_pkg::epdd_stat_t         eng_stat;
  logic [BCD_W-1:0]             bcd;
  logic [MAXD*DW-1:0]           bcd_ext;
  logic [DIGIT_COUNT:0]         lit;
  logic [MAXD-1:0]              lit_ext;
  logic [ND*DW-1:0]             digits;
  logic [ND-1:0]                shows;

  assign cap_ext = MAXW'(in_tdata[CW-1:0]);
  assign now_t   = cap_ext[TIME_BITS-1:0];
  assign ticks   = now_t - start_r;
  assign cpm_eff = (cpm_r == '0) ? epdd_pkg::CPM_W'(1) : cpm_r;
  assign divisor = {cpm_eff, 1'b0};

  assign in_tready = eng_stat.idle;
  assign in_beat   = in_tvalid && in_tready;

  assign eng_ctrl.start = in_beat && !in_tuser[0];
  assign eng_ctrl.take  = eng_stat.done && (!out_valid_r || out_tready);

  epdd_engine #(
    .DIGIT_COUNT (DIGIT_COUNT),
    .TIME_BITS   (TIME_BITS)
  ) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (eng_ctrl),
    .stat    (eng_stat),
    .ticks   (ticks),
    .speed   (speed_r),
    .divisor (divisor),
    .bcd     (bcd)
  );

  // leading-zero blanking from the top digit down
  always_comb begin
    lit[DIGIT_COUNT] = 1'b0;
    for (int i = DIGIT_COUNT - 1; i >= 0; i--) begin
      lit[i] = lit[i+1] || (bcd[i*DW +: DW] != '0);
    end
    lit[0]  = 1'b1;
    bcd_ext = (MAXD*DW)'(bcd);
    lit_ext = MAXD'(lit[DIGIT_COUNT-1:0]);
    for (int j = 0; j < ND; j++) begin
      digits[j*DW +: DW] = bcd_ext[j*DW +: DW];
      shows[j]           = lit_ext[j];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (eng_ctrl.take) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = epdd_pkg::OUT_W'({shows, digits});
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r     <= epdd_pkg::SPEED_RST;
      cpm_r       <= epdd_pkg::CPM_RST;
      start_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          epdd_pkg::REG_SPEED: speed_r <= cfg_wdata[epdd_pkg::SPEED_W-1:0];
          epdd_pkg::REG_CPM:   cpm_r   <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_beat && in_tuser[0]) begin
        start_r <= now_t;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  // a falling edge keeps the engine busy for at least the next cycle
  a_busy_after_fall: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !in_tuser[0]) |=> !in_tready)
    else $error("input taken right after a falling edge beat");

  // a rising edge never brings a result by itself
  a_rise_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser[0] && !out_tvalid) |=> !out_tvalid)
    else $error("result appeared after a rising edge beat");

  // lowest digit is always lit
  a_ones_lit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[FLD_W - ND])
    else $error("ones digit blanked");

  // every digit field is decimal, shown or blanked
  a_decimal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[3:0] <= 4'd9) && (out_tdata[7:4] <= 4'd9) &&
                   (out_tdata[11:8] <= 4'd9) && (out_tdata[15:12] <= 4'd9))
    else $error("digit out of decimal range");
`endif

endmodule
